// ===== sv/arp_pkg.sv =====
// Shared types and protocol constants for the address-resolution responder.
`default_nettype none

package arp_pkg;

    // Field values as they appear in received and sent packets
    localparam logic [15:0] HW_TYPE_OK  = 16'hFE00;
    localparam logic [15:0] PROTO_OK    = 16'h0100;
    localparam logic [15:0] OP_REQ      = 16'h0100;
    localparam logic [15:0] OP_REP      = 16'h0200;
    localparam logic [10:0] MIN_LEN     = 11'd18;
    localparam logic [7:0]  BCAST_HW    = 8'hFF;

    // Configuration register indexes
    localparam logic CFG_MY_IP = 1'b0;
    localparam logic CFG_MY_HW = 1'b1;

    // Result status codes
    localparam logic [3:0] ST_SHORT      = 4'd0;
    localparam logic [3:0] ST_REQ_NOT_ME = 4'd1;
    localparam logic [3:0] ST_REPLIED    = 4'd2;
    localparam logic [3:0] ST_LEARNED    = 4'd3;
    localparam logic [3:0] ST_REP_NOT_ME = 4'd4;
    localparam logic [3:0] ST_BAD_OP     = 4'd5;
    localparam logic [3:0] ST_HIT        = 4'd6;
    localparam logic [3:0] ST_MISS       = 4'd7;
    localparam logic [3:0] ST_NULL       = 4'd8;

    typedef struct packed {
        logic [31:0] ip;
        logic [7:0]  hw;
    } t_entry;

    typedef struct packed {
        logic        opcode;
        logic [10:0] pkt_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_op;
        logic [7:0]  sender_hw;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic        send_packet;
        logic [7:0]  dest_hw;
        logic [15:0] pkt_op;
        logic [7:0]  pkt_sender_hw;
        logic [31:0] pkt_sender_ip;
        logic [7:0]  pkt_target_hw;
        logic [31:0] pkt_target_ip;
        logic [7:0]  resolved_hw;
        logic        unexpected_reply;
        logic        wake_waiter;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/arp_table.sv =====
// Address table memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module arp_table
    import arp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_entry,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_entry
);

    t_entry           mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_valid;
    t_entry           r_rd_data;

    // Valid bits stand in for clearing the protocol addresses at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
            r_rd_data  <= mem[i_rd_addr];
        end
    end

    // An entry never written reads as empty
    assign o_rd_entry.ip = r_rd_valid ? r_rd_data.ip : 32'd0;
    assign o_rd_entry.hw = r_rd_data.hw;

endmodule

`default_nettype wire

// ===== sv/arp_ctrl.sv =====
// Sequencer: classify an item, scan the table one entry a cycle, write back, build the result.
`default_nettype none

module arp_ctrl
    import arp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_my_ip,
    input  wire logic [7:0]    i_my_hw,
    input  wire logic          i_item_valid,
    input  wire t_item         i_item,
    output logic               o_in_ready,
    input  wire logic          i_out_free,
    output logic               o_push,
    output t_result            o_result,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire t_entry        i_rd_entry,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output t_entry             o_wr_entry
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] K_RESOLVE = 2'd0;
    localparam logic [1:0] K_REQ     = 2'd1;
    localparam logic [1:0] K_REP     = 2'd2;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_kind, n_kind;
    logic [31:0]   r_key, n_key;
    logic [7:0]    r_shw, n_shw;
    logic [AW-1:0] r_ridx, n_ridx;
    logic          r_rdone, n_rdone;
    logic          r_cvalid, n_cvalid;
    logic [AW-1:0] r_cidx, n_cidx;
    logic [31:0]   r_expected, n_expected;
    logic          r_pending, n_pending;
    t_result       r_res, n_res;

    logic ip_zero;
    logic ip_match;
    logic hit;
    logic stop;

    assign ip_zero  = (i_rd_entry.ip == 32'd0);
    assign ip_match = (i_rd_entry.ip == r_key);
    assign hit      = !ip_zero && ip_match;
    assign stop     = r_cvalid && (ip_zero || ip_match || (r_cidx == LAST));

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_key      = r_key;
        n_shw      = r_shw;
        n_ridx     = r_ridx;
        n_rdone    = r_rdone;
        n_cvalid   = 1'b0;
        n_cidx     = r_cidx;
        n_expected = r_expected;
        n_pending  = r_pending;
        n_res      = r_res;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_ridx;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_cidx;
        o_wr_entry = '{ip: r_key, hw: r_shw};

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_item_valid) begin
                    n_res   = '0;
                    n_ridx  = '0;
                    n_rdone = 1'b0;
                    n_shw   = i_item.sender_hw;
                    n_key   = i_item.sender_ip;
                    n_state = S_DONE;
                    if (i_item.opcode) begin
                        if (i_item.query_ip == 32'd0) begin
                            n_res.status = ST_NULL;
                        end else begin
                            n_kind  = K_RESOLVE;
                            n_key   = i_item.query_ip;
                            n_state = S_SCAN;
                        end
                    end else if (i_item.pkt_len < MIN_LEN) begin
                        n_res.status = ST_SHORT;
                    end else if (i_item.arp_op == OP_REQ) begin
                        if (i_item.hw_type != HW_TYPE_OK || i_item.proto_type != PROTO_OK ||
                            i_item.target_ip != i_my_ip) begin
                            n_res.status = ST_REQ_NOT_ME;
                        end else begin
                            n_kind  = K_REQ;
                            n_state = S_SCAN;
                        end
                    end else if (i_item.arp_op == OP_REP) begin
                        if (i_item.target_ip != i_my_ip) begin
                            n_res.status = ST_REP_NOT_ME;
                        end else begin
                            n_kind  = K_REP;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_res.status = ST_BAD_OP;
                    end
                end
            end

            S_SCAN: begin
                // Issue the next read while checking the entry read last cycle
                if (!r_rdone) begin
                    o_rd_en  = 1'b1;
                    n_ridx   = r_ridx + 1'b1;
                    n_cvalid = 1'b1;
                    n_cidx   = r_ridx;
                    if (r_ridx == LAST) begin
                        n_rdone = 1'b1;
                    end
                end
                if (stop) begin
                    n_state  = S_DONE;
                    n_cvalid = 1'b0;
                    n_rdone  = 1'b1;
                    n_res    = '0;
                    case (r_kind)
                        K_RESOLVE: begin
                            if (hit) begin
                                n_res.status      = ST_HIT;
                                n_res.resolved_hw = i_rd_entry.hw;
                            end else begin
                                n_res.status        = ST_MISS;
                                n_res.send_packet   = 1'b1;
                                n_res.dest_hw       = BCAST_HW;
                                n_res.pkt_op        = OP_REQ;
                                n_res.pkt_sender_hw = i_my_hw;
                                n_res.pkt_sender_ip = i_my_ip;
                                n_res.pkt_target_ip = r_key;
                                n_expected          = r_key;
                                n_pending           = 1'b1;
                            end
                        end
                        K_REQ: begin
                            o_wr_en             = 1'b1;
                            n_res.status        = ST_REPLIED;
                            n_res.send_packet   = 1'b1;
                            n_res.dest_hw       = r_shw;
                            n_res.pkt_op        = OP_REP;
                            n_res.pkt_sender_hw = i_my_hw;
                            n_res.pkt_sender_ip = i_my_ip;
                            n_res.pkt_target_hw = r_shw;
                            n_res.pkt_target_ip = r_key;
                        end
                        K_REP: begin
                            o_wr_en                = 1'b1;
                            n_res.status           = ST_LEARNED;
                            n_res.unexpected_reply = !hit && (r_expected != r_key);
                            n_res.wake_waiter      = r_pending;
                            n_pending              = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                // Hold the result until the output register can take it
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rdone    <= 1'b1;
            r_cvalid   <= 1'b0;
            r_expected <= 32'd0;
            r_pending  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rdone    <= n_rdone;
            r_cvalid   <= n_cvalid;
            r_expected <= n_expected;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_key  <= n_key;
        r_shw  <= n_shw;
        r_ridx <= n_ridx;
        r_cidx <= n_cidx;
        r_res  <= n_res;
    end

`ifndef SYNTHESIS
    a_wr_only_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_SCAN) && r_cvalid)
        else $error("table write outside a scan decision");
    a_wr_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_state == S_DONE))
        else $error("scan did not finish after a table write");
    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed into a full output register");
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_item_valid) |=> !o_in_ready)
        else $error("second transfer taken while an item is in flight");
`endif

endmodule

`default_nettype wire

// ===== sv/arp_cache_responder.sv =====
// Top level of the address-resolution responder: config registers, table, sequencer, output register.
//
// Each input transfer is either a received address packet or a resolve
// query, and it produces exactly one result transfer. Items that are
// rejected on their fields alone (short packet, request or reply not for
// us, unknown opcode, null query) skip the table: their result is registered
// in the sequencer and then moved into the output register. Items that consult
// the table (resolve, request for us, reply for us) scan it from entry 0, one entry
// per cycle through the table memory's single registered read port, and stop at
// the first empty or matching entry or at the last one. One item is in work at
// a time. A finished result sits in an output register, so the next item is
// taken while the previous result still waits downstream. The table needs no
// clearing pass after reset: per-entry valid bits make unwritten entries read
// as empty. Write my_ip (index 0) and my_hw (index 1) only while no item is in
// work.
`default_nettype none

module arp_cache_responder
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    // input item channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [10:0] i_pkt_len,
    input  wire logic [15:0] i_hw_type,
    input  wire logic [15:0] i_proto_type,
    input  wire logic [15:0] i_arp_op,
    input  wire logic [7:0]  i_sender_hw,
    input  wire logic [31:0] i_sender_ip,
    input  wire logic [31:0] i_target_ip,
    input  wire logic [31:0] i_query_ip,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_status,
    output logic             o_send_packet,
    output logic [7:0]       o_dest_hw,
    output logic [15:0]      o_pkt_op,
    output logic [7:0]       o_pkt_sender_hw,
    output logic [31:0]      o_pkt_sender_ip,
    output logic [7:0]       o_pkt_target_hw,
    output logic [31:0]      o_pkt_target_ip,
    output logic [7:0]       o_resolved_hw,
    output logic             o_unexpected_reply,
    output logic             o_wake_waiter
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [31:0]   r_my_ip;
    logic [7:0]    r_my_hw;
    logic          r_out_valid;
    t_result       r_out;

    t_item         item;
    t_result       result;
    logic          push;
    logic          out_free;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_entry;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip <= 32'd0;
            r_my_hw <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MY_IP: r_my_ip <= i_cfg_wdata;
                CFG_MY_HW: r_my_hw <= i_cfg_wdata[7:0];
                default:   r_my_ip <= r_my_ip;
            endcase
        end
    end

    assign item = '{
        opcode:     i_opcode,
        pkt_len:    i_pkt_len,
        hw_type:    i_hw_type,
        proto_type: i_proto_type,
        arp_op:     i_arp_op,
        sender_hw:  i_sender_hw,
        sender_ip:  i_sender_ip,
        target_ip:  i_target_ip,
        query_ip:   i_query_ip
    };

    arp_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    arp_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_my_ip      (r_my_ip),
        .i_my_hw      (r_my_hw),
        .i_item_valid (i_valid),
        .i_item       (item),
        .o_in_ready   (o_ready),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_result     (result),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_entry   (rd_entry),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_entry   (wr_entry)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out.status;
    assign o_send_packet      = r_out.send_packet;
    assign o_dest_hw          = r_out.dest_hw;
    assign o_pkt_op           = r_out.pkt_op;
    assign o_pkt_sender_hw    = r_out.pkt_sender_hw;
    assign o_pkt_sender_ip    = r_out.pkt_sender_ip;
    assign o_pkt_target_hw    = r_out.pkt_target_hw;
    assign o_pkt_target_ip    = r_out.pkt_target_ip;
    assign o_resolved_hw      = r_out.resolved_hw;
    assign o_unexpected_reply = r_out.unexpected_reply;
    assign o_wake_waiter      = r_out.wake_waiter;

endmodule

`default_nettype wire
